[rtl/bsdpd_pkg.sv]
// ----------------------------------------------------------------------------
// bsdpd_pkg
// Shared types and constants for the single/double press detector.
// ----------------------------------------------------------------------------
package bsdpd_pkg;

   // key event codes
   localparam logic [1:0] KEY_NONE   = 2'd0;
   localparam logic [1:0] KEY_SINGLE = 2'd1;
   localparam logic [1:0] KEY_DOUBLE = 2'd2;

   // register byte addresses
   localparam int unsigned ADDR_W = 4;
   localparam logic [ADDR_W-1:0] ADDR_DEBOUNCE = 4'h0;
   localparam logic [ADDR_W-1:0] ADDR_DOUBLE   = 4'h4;
   localparam logic [ADDR_W-1:0] ADDR_SLEEP    = 4'h8;

   // register reset values
   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [15:0] DOUBLE_RESET   = 16'd400;
   localparam logic [23:0] SLEEP_RESET    = 24'd900000;

   localparam logic [15:0] MAX16 = 16'hFFFF;
   localparam logic [23:0] MAX24 = 24'hFFFFFF;

   typedef struct packed {
      logic button_level;
      logic link_connected;
   } req_type;

   typedef struct packed {
      logic [1:0] key_event;
      logic       sleep_request;
   } rsp_type;

   typedef struct packed {
      logic [15:0] debounce_ticks;
      logic [15:0] double_press_ticks;
      logic [23:0] sleep_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        previous_raw_level;
      logic        accepted_level;
      logic [15:0] stable_elapsed;
      logic        awaiting_second_press;
      logic [15:0] press_gap_elapsed;
      logic [23:0] idle_elapsed;
      logic        asleep;
   } state_type;

   localparam state_type STATE_RESET = '{
      previous_raw_level:    1'b1,
      accepted_level:        1'b1,
      stable_elapsed:        16'd0,
      awaiting_second_press: 1'b0,
      press_gap_elapsed:     16'd0,
      idle_elapsed:          24'd0,
      asleep:                1'b0
   };

endpackage

[rtl/button_single_double_press_detector.sv]
// ----------------------------------------------------------------------------
// button_single_double_press_detector
// Debounced single/double press detector with latched idle sleep request.
// ----------------------------------------------------------------------------
// Path: an accepted req word loads the input register, then its result loads
//   the result register, which drives rsp, when the input word advances.
// Throughput: one word per cycle while rsp_stall is low, set by the
//   combinational tick logic that updates the state registers.
// Reset: synchronous, active high; timing registers return to 50/400/900000,
//   detector state to released/idle/awake. No clearing pass.
// ----------------------------------------------------------------------------
module button_single_double_press_detector (
   input  logic                         clock,
   input  logic                         reset,
   // tick words in
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bsdpd_pkg::req_type           req_data,
   // result words out
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bsdpd_pkg::rsp_type           rsp_data,
   // register port
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [bsdpd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   bsdpd_pkg::cfg_type   cfg;

   // input register
   logic                 in_valid_ff;
   logic                 in_valid_in;
   bsdpd_pkg::req_type   in_data_ff;

   // result register
   logic                 out_valid_ff;
   logic                 out_valid_in;
   bsdpd_pkg::rsp_type   out_data_ff;

   // detector state
   bsdpd_pkg::state_type state_ff;
   bsdpd_pkg::state_type state_in;
   bsdpd_pkg::rsp_type   tick_rsp;

   logic                 advance;   // input word moves into result register
   logic                 req_take;

   bsdpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bsdpd_tick u_tick (
      .item (in_data_ff),
      .cfg  (cfg),
      .cur  (state_ff),
      .nxt  (state_in),
      .rsp  (tick_rsp)
   );

   // Result register frees when empty or being taken this cycle; the input
   // register frees when it advances, so both sides keep moving every cycle unless rsp_stall holds them.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= bsdpd_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= tick_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // sleep latches until reset
   a_sleep_latched: assert property (@(posedge clock) disable iff (reset)
      state_ff.asleep |=> state_ff.asleep)
      else $error("sleep latch dropped");

   // asleep block holds its state
   a_asleep_frozen: assert property (@(posedge clock) disable iff (reset)
      state_ff.asleep |=> $stable(state_ff))
      else $error("state changed while asleep");

   // no event code outside none/single/double
   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.key_event == bsdpd_pkg::KEY_NONE ||
                     rsp_data.key_event == bsdpd_pkg::KEY_SINGLE ||
                     rsp_data.key_event == bsdpd_pkg::KEY_DOUBLE))
      else $error("bad key event code");

   // input side only stalls behind a held word
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without backpressure");

endmodule

[rtl/bsdpd_csr.sv]
// ----------------------------------------------------------------------------
// bsdpd_csr
// APB-style register file holding the three timing registers.
// ----------------------------------------------------------------------------
module bsdpd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [bsdpd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready,
   output bsdpd_pkg::cfg_type           cfg
);

   bsdpd_pkg::cfg_type cfg_ff;
   bsdpd_pkg::cfg_type cfg_in;
   logic               wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr)
            bsdpd_pkg::ADDR_DEBOUNCE: cfg_in.debounce_ticks      = csr_pwdata[15:0];
            bsdpd_pkg::ADDR_DOUBLE:   cfg_in.double_press_ticks  = csr_pwdata[15:0];
            bsdpd_pkg::ADDR_SLEEP:    cfg_in.sleep_timeout_ticks = csr_pwdata[23:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks      <= bsdpd_pkg::DEBOUNCE_RESET;
         cfg_ff.double_press_ticks  <= bsdpd_pkg::DOUBLE_RESET;
         cfg_ff.sleep_timeout_ticks <= bsdpd_pkg::SLEEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr)
         bsdpd_pkg::ADDR_DEBOUNCE: csr_prdata = {16'd0, cfg_ff.debounce_ticks};
         bsdpd_pkg::ADDR_DOUBLE:   csr_prdata = {16'd0, cfg_ff.double_press_ticks};
         bsdpd_pkg::ADDR_SLEEP:    csr_prdata = {8'd0, cfg_ff.sleep_timeout_ticks};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

[rtl/bsdpd_tick.sv]
// ----------------------------------------------------------------------------
// bsdpd_tick
// One-tick next-state and event logic: debounce, press classification,
// idle timeout.
// ----------------------------------------------------------------------------
module bsdpd_tick (
   input  bsdpd_pkg::req_type   item,
   input  bsdpd_pkg::cfg_type   cfg,
   input  bsdpd_pkg::state_type cur,
   output bsdpd_pkg::state_type nxt,
   output bsdpd_pkg::rsp_type   rsp
);

   logic [1:0] key_event;

   always_comb begin
      nxt       = cur;
      key_event = bsdpd_pkg::KEY_NONE;

      if (!cur.asleep) begin
         // saturating counters run regardless of link state
         nxt.stable_elapsed    = (cur.stable_elapsed == bsdpd_pkg::MAX16) ?
                                 bsdpd_pkg::MAX16 : cur.stable_elapsed + 16'd1;
         nxt.press_gap_elapsed = (cur.press_gap_elapsed == bsdpd_pkg::MAX16) ?
                                 bsdpd_pkg::MAX16 : cur.press_gap_elapsed + 16'd1;
         nxt.idle_elapsed      = (cur.idle_elapsed == bsdpd_pkg::MAX24) ?
                                 bsdpd_pkg::MAX24 : cur.idle_elapsed + 24'd1;

         if (item.link_connected) begin
            if (item.button_level != cur.previous_raw_level) begin
               nxt.stable_elapsed = 16'd0;
            end

            if (nxt.stable_elapsed > cfg.debounce_ticks) begin
               // falling edge of the accepted level is a press
               if (!item.button_level && cur.accepted_level) begin
                  nxt.idle_elapsed = 24'd0;
                  if (cur.awaiting_second_press &&
                      nxt.press_gap_elapsed < cfg.double_press_ticks) begin
                     key_event                 = bsdpd_pkg::KEY_DOUBLE;
                     nxt.awaiting_second_press = 1'b0;
                  end else begin
                     nxt.press_gap_elapsed     = 16'd0;
                     nxt.awaiting_second_press = 1'b1;
                  end
               end
               nxt.accepted_level = item.button_level;
            end

            // window ran out: single press
            if (nxt.awaiting_second_press &&
                nxt.press_gap_elapsed >= cfg.double_press_ticks) begin
               key_event                 = bsdpd_pkg::KEY_SINGLE;
               nxt.awaiting_second_press = 1'b0;
            end

            if (nxt.idle_elapsed > cfg.sleep_timeout_ticks) begin
               nxt.asleep = 1'b1;
            end

            nxt.previous_raw_level = item.button_level;
         end
      end

      rsp.key_event     = key_event;
      rsp.sleep_request = nxt.asleep;
   end

endmodule
